FILE: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the tick task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TASK_COUNT = 8;
  localparam int TASK_W     = $clog2(TASK_COUNT);

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_SUSPEND = 3'd2,
    OP_RESUME  = 3'd3,
    OP_KILL    = 3'd4
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // tick accepted: rewind the walk
    logic apply;   // table operation accepted
    logic step;    // process the slot under the walk pointer
  } tts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register can take a beat this cycle
    logic ptr_last;  // walk pointer is on the final slot
  } tts_status_t;

endpackage

FILE: rtl/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl
// Controller: accepts operations and sequences the slot walk of a tick.
// ----------------------------------------------------------------------------
module tts_ctrl import tts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  tts_status_t status,
  output tts_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.start = accept && (operation == OP_TICK);
    cmd.apply = accept && (operation != OP_TICK);
    cmd.step  = (state == ST_WALK) && status.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (cmd.start) state_next = ST_WALK;
      ST_WALK: if (cmd.step && status.ptr_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

FILE: rtl/tts_datapath.sv
// ----------------------------------------------------------------------------
// tts_datapath
// Slot table, walk pointer and result register of the tick task scheduler.
// ----------------------------------------------------------------------------
module tts_datapath import tts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tts_cmd_t    cmd,
  output tts_status_t status,
  input  logic [2:0]  operation,
  input  logic [2:0]  task_index,
  input  logic [15:0] period,
  input  logic [7:0]  init_delay,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        fired,
  output logic [2:0]  fired_task,
  output logic        last
);

  logic [TASK_COUNT-1:0] slot_valid;
  logic [TASK_COUNT-1:0] slot_paused;
  logic [15:0]           slot_period    [TASK_COUNT];
  logic [15:0]           slot_countdown [TASK_COUNT];

  logic [TASK_W-1:0]     ptr;
  logic                  any_fired;

  logic [TASK_COUNT-1:0] due;
  logic                  idx_ok;
  logic [TASK_W-1:0]     idx;
  logic                  live;
  logic                  hit;
  logic                  later_hit;
  logic [TASK_W:0]       ptr_plus;

  assign idx    = task_index[TASK_W-1:0];
  assign idx_ok = (32'(task_index) < TASK_COUNT);

  // slots that would fire if reached now; slots ahead of the pointer are untouched
  always_comb begin
    for (int i = 0; i < TASK_COUNT; i++) begin
      due[i] = slot_valid[i] && !slot_paused[i] && (slot_countdown[i] == 16'd0);
    end
  end

  assign live      = slot_valid[ptr] && !slot_paused[ptr];
  assign hit       = due[ptr];
  assign ptr_plus  = {1'b0, ptr} + 1'b1;
  assign later_hit = |(due >> ptr_plus);

  assign status.out_free = !out_valid || out_ready;
  assign status.ptr_last = (ptr == TASK_W'(TASK_COUNT - 1));

  // control state of the table and walk
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      slot_paused <= '0;
      ptr         <= '0;
      any_fired   <= 1'b0;
    end else begin
      if (cmd.start) begin
        ptr       <= '0;
        any_fired <= 1'b0;
      end else if (cmd.step) begin
        ptr       <= status.ptr_last ? '0 : ptr_plus[TASK_W-1:0];
        any_fired <= any_fired || hit;
      end
      if (cmd.apply && idx_ok) begin
        case (op_t'(operation))
          OP_CREATE: begin
            slot_valid[idx]  <= 1'b1;
            slot_paused[idx] <= 1'b0;
          end
          OP_SUSPEND: slot_paused[idx] <= 1'b1;
          OP_RESUME:  slot_paused[idx] <= 1'b0;
          OP_KILL:    slot_valid[idx]  <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // period and countdown storage; contents only matter once created
  always_ff @(posedge clk) begin
    if (cmd.step && live) begin
      slot_countdown[ptr] <= hit ? slot_period[ptr] : slot_countdown[ptr] - 16'd1;
    end else if (cmd.apply && idx_ok) begin
      case (op_t'(operation))
        OP_CREATE: begin
          slot_period[idx]    <= period;
          slot_countdown[idx] <= {8'd0, init_delay};
        end
        OP_KILL: begin
          slot_period[idx]    <= 16'd0;
          slot_countdown[idx] <= 16'd0;
        end
        default: ;
      endcase
    end
  end

  // result register: one beat per firing, or one empty beat closing a quiet tick
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && (hit || (status.ptr_last && !any_fired))) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (hit) begin
        fired      <= 1'b1;
        fired_task <= 3'(ptr);
        last       <= !later_hit;
      end else if (status.ptr_last && !any_fired) begin
        fired      <= 1'b0;
        fired_task <= 3'd0;
        last       <= 1'b1;
      end
    end
  end

  // a step must never overwrite a beat still waiting downstream
  a_step_room: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (!out_valid || out_ready))
    else $error("walk step while result register is stalled");

  a_start_rewinds: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (ptr == '0) && !any_fired)
    else $error("tick did not rewind the walk");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fired) |-> last)
    else $error("empty tick result not marked last");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.step && (cmd.start || cmd.apply)))
    else $error("operation accepted during a walk");

endmodule

FILE: rtl/tick_task_scheduler.sv
// ----------------------------------------------------------------------------
// tick_task_scheduler
// Time-triggered cooperative scheduler: task slot table driven by ticks.
// ----------------------------------------------------------------------------
// Create, suspend, resume and kill give no beat.
// A tick walks the slots one per cycle while the output is not stalled, and
// the input is not ready until the walk of the final slot; a firing beat
// appears the cycle after its slot is walked.
// The walk pauses while the result register is stalled.
// Sync reset clears all valid/paused marks, the walk and the result register.
module tick_task_scheduler import tts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [2:0]  task_index,
  input  logic [15:0] period,
  input  logic [7:0]  init_delay,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        fired,
  output logic [2:0]  fired_task,
  output logic        last
);

  tts_cmd_t    cmd;
  tts_status_t status;

  tts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  tts_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .operation   (operation),
    .task_index  (task_index),
    .period      (period),
    .init_delay  (init_delay),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .fired       (fired),
    .fired_task  (fired_task),
    .last        (last)
  );

endmodule
